@@ rtl/stss_pkg.sv @@
// ----------------------------------------------------------------------------
// stss_pkg
// Types, constants and table functions of the synthesizer tune serializer.
// ----------------------------------------------------------------------------
package stss_pkg;

  localparam int unsigned ADDR_BITS   = 4;
  localparam int unsigned DATA_BITS   = 20;
  localparam int unsigned FRAME_BITS  = ADDR_BITS + 1 + DATA_BITS;
  localparam int unsigned PHASES      = 2 * FRAME_BITS + 1;
  localparam int unsigned PHASE_W     = $clog2(PHASES);
  localparam int unsigned CHAN_W      = 6;
  localparam int unsigned FREQ_W      = 16;
  localparam int unsigned ROM_W       = 13;
  localparam int unsigned LEVEL_W     = 8;

  localparam logic [ADDR_BITS-1:0] SYNTH_REG_ADDR = 4'h1;
  localparam logic [FREQ_W-1:0]    FREQ_OFFSET    = 16'd479;
  localparam logic [PHASE_W-1:0]   LAST_PHASE     = PHASE_W'(PHASES - 1);

  typedef enum logic [1:0] {
    ACT_TUNE_TABLE  = 2'd0,
    ACT_TUNE_RAW    = 2'd1,
    ACT_SCAN_START  = 2'd2,
    ACT_SCAN_SAMPLE = 2'd3
  } action_e;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  scan_done;
    logic [CHAN_W-1:0]     best_channel;
  } frame_t;

  function automatic logic [ROM_W-1:0] rom_freq(input logic [CHAN_W-1:0] idx);
    logic [ROM_W-1:0] f;
    unique case (idx)
      6'd0:  f = 13'd5865;  6'd1:  f = 13'd5845;  6'd2:  f = 13'd5825;
      6'd3:  f = 13'd5805;  6'd4:  f = 13'd5785;  6'd5:  f = 13'd5765;
      6'd6:  f = 13'd5745;  6'd7:  f = 13'd5725;  6'd8:  f = 13'd5733;
      6'd9:  f = 13'd5752;  6'd10: f = 13'd5771;  6'd11: f = 13'd5790;
      6'd12: f = 13'd5809;  6'd13: f = 13'd5828;  6'd14: f = 13'd5847;
      6'd15: f = 13'd5866;  6'd16: f = 13'd5705;  6'd17: f = 13'd5685;
      6'd18: f = 13'd5665;  6'd19: f = 13'd5645;  6'd20: f = 13'd5885;
      6'd21: f = 13'd5905;  6'd22: f = 13'd5925;  6'd23: f = 13'd5945;
      6'd24: f = 13'd5740;  6'd25: f = 13'd5760;  6'd26: f = 13'd5780;
      6'd27: f = 13'd5800;  6'd28: f = 13'd5820;  6'd29: f = 13'd5840;
      6'd30: f = 13'd5860;  6'd31: f = 13'd5880;  6'd32: f = 13'd5658;
      6'd33: f = 13'd5695;  6'd34: f = 13'd5732;  6'd35: f = 13'd5769;
      6'd36: f = 13'd5806;  6'd37: f = 13'd5843;  6'd38: f = 13'd5880;
      6'd39: f = 13'd5917;  6'd40: f = 13'd5362;  6'd41: f = 13'd5399;
      6'd42: f = 13'd5436;  6'd43: f = 13'd5473;  6'd44: f = 13'd5510;
      6'd45: f = 13'd5547;  6'd46: f = 13'd5584;  6'd47: f = 13'd5621;
      default: f = '0;
    endcase
    return f;
  endfunction

  // lo = (f - 479) / 2, data = (lo / 32) << 7 | lo % 32
  function automatic logic [DATA_BITS-1:0] divider_word(input logic [FREQ_W-1:0] f);
    logic [FREQ_W-1:0] diff;
    logic [14:0]       lo;
    diff = (f >= FREQ_OFFSET) ? (f - FREQ_OFFSET) : '0;
    lo   = diff[15:1];
    return {3'b000, lo[14:5], 2'b00, lo[4:0]};
  endfunction

endpackage

@@ rtl/stss_if.sv @@
// ----------------------------------------------------------------------------
// stss_if
// Valid/ready channels for tune commands and bus phases.
// ----------------------------------------------------------------------------
interface stss_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic [stss_pkg::CHAN_W-1:0]     channel_index;
  logic [stss_pkg::FREQ_W-1:0]     frequency_mhz;
  logic [stss_pkg::LEVEL_W-1:0]    signal_level;

  modport source (output valid, action, channel_index, frequency_mhz, signal_level,
                  input ready);
  modport sink   (input valid, action, channel_index, frequency_mhz, signal_level,
                  output ready);
endinterface

interface stss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        serial_clock;
  logic                        serial_data;
  logic                        latch_enable;
  logic [stss_pkg::CHAN_W-1:0] best_channel;
  logic                        scan_done;
  logic                        last;

  modport source (output valid, serial_clock, serial_data, latch_enable, best_channel,
                  scan_done, last, input ready);
  modport sink   (input valid, serial_clock, serial_data, latch_enable, best_channel,
                  scan_done, last, output ready);
endinterface

@@ rtl/stss_frame_calc.sv @@
// ----------------------------------------------------------------------------
// stss_frame_calc
// Decodes a command, updates scan state and registers the frame to send.
// ----------------------------------------------------------------------------
module stss_frame_calc #(
  parameter int unsigned NUM_CHANNELS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  stss_in_if.sink            in_i,
  output stss_pkg::frame_t   frame_o,
  output logic               frame_valid_o,
  input  logic               frame_take_i
);

  localparam logic [stss_pkg::CHAN_W:0] NumCh = (stss_pkg::CHAN_W + 1)'(NUM_CHANNELS);

  logic                             active_q, active_d;
  logic [stss_pkg::CHAN_W-1:0]      pos_q, pos_d;
  logic [stss_pkg::LEVEL_W-1:0]     peak_q, peak_d;
  logic [stss_pkg::CHAN_W-1:0]      best_q, best_d;
  logic                             hold_valid_q, hold_valid_d;
  stss_pkg::frame_t                 hold_q;

  logic                             accept;
  logic                             emit;
  logic                             done;
  logic                             use_rom;
  logic [stss_pkg::CHAN_W-1:0]      rom_idx;
  logic [stss_pkg::CHAN_W:0]        pos_inc;
  logic [stss_pkg::FREQ_W-1:0]      freq;
  stss_pkg::frame_t                 frame_d;

  assign in_i.ready = !hold_valid_q || frame_take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    peak_d   = peak_q;
    best_d   = best_q;
    emit     = 1'b0;
    done     = 1'b0;
    use_rom  = 1'b1;
    rom_idx  = in_i.channel_index;
    unique case (stss_pkg::action_e'(in_i.action))
      stss_pkg::ACT_TUNE_TABLE: begin
        emit = ({1'b0, in_i.channel_index} < NumCh);
      end
      stss_pkg::ACT_TUNE_RAW: begin
        emit    = 1'b1;
        use_rom = 1'b0;
      end
      stss_pkg::ACT_SCAN_START: begin
        emit     = 1'b1;
        active_d = 1'b1;
        pos_d    = '0;
        peak_d   = '0;
        rom_idx  = '0;
      end
      stss_pkg::ACT_SCAN_SAMPLE: begin
        if (active_q) begin
          emit = 1'b1;
          if (in_i.signal_level > peak_q) begin
            peak_d = in_i.signal_level;
            best_d = pos_q;
          end
          if (pos_inc >= NumCh) begin
            active_d = 1'b0;
            pos_d    = '0;
            done     = 1'b1;
            rom_idx  = best_d;
          end else begin
            pos_d   = pos_inc[stss_pkg::CHAN_W-1:0];
            rom_idx = pos_inc[stss_pkg::CHAN_W-1:0];
          end
        end
      end
      default: ;
    endcase
    freq = use_rom ? {3'b000, stss_pkg::rom_freq(rom_idx)} : in_i.frequency_mhz;
    frame_d.frame        = {stss_pkg::divider_word(freq), 1'b1, stss_pkg::SYNTH_REG_ADDR};
    frame_d.scan_done    = done;
    frame_d.best_channel = best_d;
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = emit;
    end else if (frame_take_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      pos_q        <= '0;
      peak_q       <= '0;
      best_q       <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      if (accept) begin
        active_q <= active_d;
        pos_q    <= pos_d;
        peak_q   <= peak_d;
        best_q   <= best_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      hold_q <= frame_d;
    end
  end

  assign frame_o       = hold_q;
  assign frame_valid_o = hold_valid_q;

endmodule

@@ rtl/stss_serializer.sv @@
// ----------------------------------------------------------------------------
// stss_serializer
// Shifts a frame out LSB first as clock-low/clock-high phases plus a latch.
// ----------------------------------------------------------------------------
module stss_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stss_pkg::frame_t   frame_i,
  input  logic               frame_valid_i,
  output logic               frame_take_o,
  stss_out_if.source         out_o
);

  logic                                busy_q, busy_d;
  logic [stss_pkg::PHASE_W-1:0]        phase_q, phase_d;
  logic [stss_pkg::FRAME_BITS-1:0]     shift_q, shift_d;
  logic                                done_q;
  logic [stss_pkg::CHAN_W-1:0]         best_q;
  logic                                fire;
  logic                                is_last;

  assign is_last      = (phase_q == stss_pkg::LAST_PHASE);
  assign fire         = out_o.valid && out_o.ready;
  assign frame_take_o = frame_valid_i && (!busy_q || (fire && is_last));

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    shift_d = shift_q;
    if (frame_take_o) begin
      busy_d  = 1'b1;
      phase_d = '0;
      shift_d = frame_i.frame;
    end else if (fire) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        phase_d = phase_q + 1'b1;
        if (phase_q[0]) begin
          shift_d = shift_q >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (frame_take_o) begin
      done_q <= frame_i.scan_done;
      best_q <= frame_i.best_channel;
    end
  end

  // after the last data bit the shifter is empty, so data reads 0 on the latch phase
  assign out_o.valid        = busy_q;
  assign out_o.serial_clock = phase_q[0];
  assign out_o.serial_data  = shift_q[0];
  assign out_o.latch_enable = is_last;
  assign out_o.best_channel = best_q;
  assign out_o.scan_done    = done_q;
  assign out_o.last         = is_last;

endmodule

@@ rtl/synth_tune_scan_serializer_unit.sv @@
// ----------------------------------------------------------------------------
// synth_tune_scan_serializer_unit
// Synthesizer tuning and channel scan, emitted as three-wire bus phases.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_i    | in  | one command: table tune, raw tune, scan start, scan sample
//  out_o   | out | one bus phase: clock, data, latch, best channel, done, last
//
// A command is decoded and its frame word registered; a frame then leaves as
// 51 phase transactions, one per cycle while out_o is ready. The serializer
// sets the rate of tuning commands. One decoded frame waits in a holding
// register, so in_i stays ready while it is free.
// Reset clears scan state and all valid flags. Stalls on out_o hold the phase.
// ----------------------------------------------------------------------------
module synth_tune_scan_serializer_unit #(
  parameter int unsigned NUM_CHANNELS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stss_in_if.sink    in_i,
  stss_out_if.source out_o
);

  stss_pkg::frame_t frame;
  logic             frame_valid;
  logic             frame_take;

  stss_frame_calc #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .frame_o       (frame),
    .frame_valid_o (frame_valid),
    .frame_take_i  (frame_take)
  );

  stss_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .frame_valid_i (frame_valid),
    .frame_take_o  (frame_take),
    .out_o         (out_o)
  );

endmodule
